### design/two_sensor_read_sequencer_macros.svh
// assertion macros for the two-sensor read sequencer
// included by the top level, no other dependencies
`ifndef TWO_SENSOR_READ_SEQUENCER_MACROS_SVH
`define TWO_SENSOR_READ_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TSRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define TSRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/tsrs_pkg.sv
// shared types, codes and constants for the two-sensor read sequencer
// no dependencies
package tsrs_pkg;

  localparam int TIME_BITS = 32;

  typedef logic [TIME_BITS-1:0] time_t;

  // word kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_RX   = 2'd2;

  // sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HTX   = 3'd1;
  localparam logic [2:0] PH_HWAIT = 3'd2;
  localparam logic [2:0] PH_HRX   = 3'd3;
  localparam logic [2:0] PH_GTX   = 3'd4;
  localparam logic [2:0] PH_GWAIT = 3'd5;
  localparam logic [2:0] PH_GRX   = 3'd6;
  localparam logic [2:0] PH_PROC  = 3'd7;

  // bus commands, also used for the pending transfer
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_HTX  = 3'd1;
  localparam logic [2:0] CMD_HRX  = 3'd2;
  localparam logic [2:0] CMD_GTX  = 3'd3;
  localparam logic [2:0] CMD_GRX  = 3'd4;

  // result status
  localparam logic [1:0] ST_READY     = 2'd0;
  localparam logic [1:0] ST_NO_UPDATE = 2'd1;
  localparam logic [1:0] ST_HUM_FAIL  = 2'd2;
  localparam logic [1:0] ST_GAS_FAIL  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_TIMEOUT       = 2'd1;
  localparam logic [1:0] REG_HUM_DELAY     = 2'd2;
  localparam logic [1:0] REG_GAS_DELAY     = 2'd3;

  // reset values
  localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd1000;
  localparam logic [15:0] TIMEOUT_RESET       = 16'd50;
  localparam logic [15:0] HUM_DELAY_RESET     = 16'd16;
  localparam logic [15:0] GAS_DELAY_RESET     = 16'd30;
  localparam logic [15:0] HUMIDITY_RESET      = 16'h8000;
  localparam logic [15:0] TEMPERATURE_RESET   = 16'h6666;

  typedef struct packed {
    logic [31:0] cycle_period;
    logic [15:0] transfer_timeout_ms;
    logic [15:0] humidity_delay_ms;
    logic [15:0] gas_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic        bus_match;
    logic        launch_ok;
    logic        response_ok;
    logic [15:0] humidity_raw_in;
    logic [15:0] temperature_raw_in;
    logic [15:0] gas_raw_in;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  command;
    logic [15:0] comp_humidity;
    logic [15:0] comp_temperature;
    logic [15:0] gas_raw;
    logic        sample_valid;
    logic [31:0] good_cycles;
    logic [31:0] failed_cycles;
    logic [31:0] timeouts;
    logic [31:0] humidity_reads_ok;
    logic [31:0] humidity_read_errors;
  } result_t;

endpackage

### design/tsrs_cfg.sv
// configuration registers of the two-sensor read sequencer
// depends on tsrs_pkg
module tsrs_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output tsrs_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycle_period        <= tsrs_pkg::SAMPLE_PERIOD_RESET;
      cfg.transfer_timeout_ms <= tsrs_pkg::TIMEOUT_RESET;
      cfg.humidity_delay_ms   <= tsrs_pkg::HUM_DELAY_RESET;
      cfg.gas_delay_ms        <= tsrs_pkg::GAS_DELAY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tsrs_pkg::REG_SAMPLE_PERIOD: cfg.cycle_period        <= cfg_data;
        tsrs_pkg::REG_TIMEOUT:       cfg.transfer_timeout_ms <= cfg_data[15:0];
        tsrs_pkg::REG_HUM_DELAY:     cfg.humidity_delay_ms   <= cfg_data[15:0];
        tsrs_pkg::REG_GAS_DELAY:     cfg.gas_delay_ms        <= cfg_data[15:0];
      endcase
    end
  end

endmodule

### design/tsrs_in_stage.sv
// input register of the two-sensor read sequencer
// depends on tsrs_pkg
module tsrs_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  tsrs_pkg::item_t in_item,
  input  logic            fire,
  output logic            full,
  output tsrs_pkg::item_t item
);

  // stall unless the stage is empty or the held word leaves this cycle
  assign in_stall = full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (fire) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

### design/tsrs_core.sv
// sequencer state and per-word step logic
// depends on tsrs_pkg
module tsrs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  tsrs_pkg::item_t   item,
  input  tsrs_pkg::cfg_t    cfg,
  output tsrs_pkg::result_t result_next
);

  logic [2:0]      phase, phase_next;
  tsrs_pkg::time_t last_start, last_start_next;
  tsrs_pkg::time_t entry_time, entry_time_next;
  logic [2:0]      pending, pending_next;
  logic            finished, finished_next;
  logic [15:0]     held_hum, held_hum_next;
  logic [15:0]     held_temp, held_temp_next;
  logic [15:0]     held_gas, held_gas_next;
  logic            gas_seen, gas_seen_next;
  logic [31:0]     ok_cnt, ok_cnt_next;
  logic [31:0]     fail_cnt, fail_cnt_next;
  logic [31:0]     tmo_cnt, tmo_cnt_next;
  logic [31:0]     hum_ok_cnt, hum_ok_cnt_next;
  logic [31:0]     hum_fail_cnt, hum_fail_cnt_next;

  tsrs_pkg::time_t now_t;
  tsrs_pkg::time_t dt;
  tsrs_pkg::time_t since_start;
  logic            timed_out;

  assign now_t       = item.now_ms[tsrs_pkg::TIME_BITS-1:0];
  assign dt          = now_t - entry_time;
  assign since_start = now_t - last_start;
  assign timed_out   = 32'(dt) > 32'(cfg.transfer_timeout_ms);

  always_comb begin
    logic [1:0] status;
    logic [2:0] command;
    logic       hum_fail;
    logic       gas_fail;

    phase_next        = phase;
    last_start_next   = last_start;
    entry_time_next   = entry_time;
    pending_next      = pending;
    finished_next     = finished;
    held_hum_next     = held_hum;
    held_temp_next    = held_temp;
    held_gas_next     = held_gas;
    gas_seen_next     = gas_seen;
    ok_cnt_next       = ok_cnt;
    fail_cnt_next     = fail_cnt;
    tmo_cnt_next      = tmo_cnt;
    hum_ok_cnt_next   = hum_ok_cnt;
    hum_fail_cnt_next = hum_fail_cnt;
    status            = tsrs_pkg::ST_NO_UPDATE;
    command           = tsrs_pkg::CMD_NONE;
    hum_fail          = 1'b0;
    gas_fail          = 1'b0;

    if (fire) begin
      case (item.kind)
        tsrs_pkg::KIND_TX: begin
          if (item.bus_match && (pending == tsrs_pkg::CMD_HTX ||
                                 pending == tsrs_pkg::CMD_GTX)) begin
            finished_next = 1'b1;
          end
        end
        tsrs_pkg::KIND_RX: begin
          if (item.bus_match && (pending == tsrs_pkg::CMD_HRX ||
                                 pending == tsrs_pkg::CMD_GRX)) begin
            finished_next = 1'b1;
          end
        end
        tsrs_pkg::KIND_TICK: begin
          unique case (phase) inside
            tsrs_pkg::PH_IDLE: begin
              if (32'(since_start) >= cfg.cycle_period) begin
                last_start_next = now_t;
                finished_next   = 1'b0;
                pending_next    = tsrs_pkg::CMD_HTX;
                command         = tsrs_pkg::CMD_HTX;
                if (!item.launch_ok) begin
                  hum_fail = 1'b1;
                end else begin
                  phase_next      = tsrs_pkg::PH_HTX;
                  entry_time_next = now_t;
                end
              end
            end
            tsrs_pkg::PH_HTX, tsrs_pkg::PH_GTX: begin
              if (finished) begin
                pending_next    = tsrs_pkg::CMD_NONE;
                finished_next   = 1'b0;
                phase_next      = (phase == tsrs_pkg::PH_HTX) ? tsrs_pkg::PH_HWAIT
                                                               : tsrs_pkg::PH_GWAIT;
                entry_time_next = now_t;
              end else if (timed_out) begin
                tmo_cnt_next = tmo_cnt + 32'd1;
                hum_fail     = (phase == tsrs_pkg::PH_HTX);
                gas_fail     = (phase != tsrs_pkg::PH_HTX);
              end
            end
            tsrs_pkg::PH_HWAIT: begin
              if (32'(dt) >= 32'(cfg.humidity_delay_ms)) begin
                pending_next  = tsrs_pkg::CMD_HRX;
                finished_next = 1'b0;
                command       = tsrs_pkg::CMD_HRX;
                if (!item.launch_ok) begin
                  hum_fail = 1'b1;
                end else begin
                  phase_next      = tsrs_pkg::PH_HRX;
                  entry_time_next = now_t;
                end
              end
            end
            tsrs_pkg::PH_HRX: begin
              if (!finished) begin
                if (timed_out) begin
                  tmo_cnt_next = tmo_cnt + 32'd1;
                  hum_fail     = 1'b1;
                end
              end else if (!item.response_ok) begin
                hum_fail = 1'b1;
              end else begin
                held_hum_next   = item.humidity_raw_in;
                held_temp_next  = item.temperature_raw_in;
                hum_ok_cnt_next = hum_ok_cnt + 32'd1;
                pending_next    = tsrs_pkg::CMD_GTX;
                finished_next   = 1'b0;
                command         = tsrs_pkg::CMD_GTX;
                if (!item.launch_ok) begin
                  gas_fail = 1'b1;
                end else begin
                  phase_next      = tsrs_pkg::PH_GTX;
                  entry_time_next = now_t;
                end
              end
            end
            tsrs_pkg::PH_GWAIT: begin
              if (32'(dt) >= 32'(cfg.gas_delay_ms)) begin
                pending_next  = tsrs_pkg::CMD_GRX;
                finished_next = 1'b0;
                command       = tsrs_pkg::CMD_GRX;
                if (!item.launch_ok) begin
                  gas_fail = 1'b1;
                end else begin
                  phase_next      = tsrs_pkg::PH_GRX;
                  entry_time_next = now_t;
                end
              end
            end
            tsrs_pkg::PH_GRX: begin
              if (!finished) begin
                if (timed_out) begin
                  tmo_cnt_next = tmo_cnt + 32'd1;
                  gas_fail     = 1'b1;
                end
              end else begin
                pending_next  = tsrs_pkg::CMD_NONE;
                finished_next = 1'b0;
                if (!item.response_ok) begin
                  gas_fail = 1'b1;
                end else begin
                  held_gas_next   = item.gas_raw_in;
                  phase_next      = tsrs_pkg::PH_PROC;
                  entry_time_next = now_t;
                end
              end
            end
            tsrs_pkg::PH_PROC: begin
              gas_seen_next   = 1'b1;
              ok_cnt_next     = ok_cnt + 32'd1;
              phase_next      = tsrs_pkg::PH_IDLE;
              entry_time_next = now_t;
              status          = tsrs_pkg::ST_READY;
            end
          endcase
        end
        default: begin
        end
      endcase

      // failure exits share one path back to idle
      if (hum_fail || gas_fail) begin
        pending_next    = tsrs_pkg::CMD_NONE;
        finished_next   = 1'b0;
        fail_cnt_next   = fail_cnt + 32'd1;
        phase_next      = tsrs_pkg::PH_IDLE;
        entry_time_next = now_t;
      end
      if (hum_fail) begin
        hum_fail_cnt_next = hum_fail_cnt + 32'd1;
        status            = tsrs_pkg::ST_HUM_FAIL;
      end else if (gas_fail) begin
        status = tsrs_pkg::ST_GAS_FAIL;
      end
    end

    result_next.status               = status;
    result_next.command              = command;
    result_next.comp_humidity        = held_hum_next;
    result_next.comp_temperature     = held_temp_next;
    result_next.gas_raw              = held_gas_next;
    result_next.sample_valid         = gas_seen_next;
    result_next.good_cycles          = ok_cnt_next;
    result_next.failed_cycles        = fail_cnt_next;
    result_next.timeouts             = tmo_cnt_next;
    result_next.humidity_reads_ok    = hum_ok_cnt_next;
    result_next.humidity_read_errors = hum_fail_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tsrs_pkg::PH_IDLE;
      last_start   <= '0;
      entry_time   <= '0;
      pending      <= tsrs_pkg::CMD_NONE;
      finished     <= 1'b0;
      held_hum     <= tsrs_pkg::HUMIDITY_RESET;
      held_temp    <= tsrs_pkg::TEMPERATURE_RESET;
      held_gas     <= '0;
      gas_seen     <= 1'b0;
      ok_cnt       <= '0;
      fail_cnt     <= '0;
      tmo_cnt      <= '0;
      hum_ok_cnt   <= '0;
      hum_fail_cnt <= '0;
    end else begin
      phase        <= phase_next;
      last_start   <= last_start_next;
      entry_time   <= entry_time_next;
      pending      <= pending_next;
      finished     <= finished_next;
      held_hum     <= held_hum_next;
      held_temp    <= held_temp_next;
      held_gas     <= held_gas_next;
      gas_seen     <= gas_seen_next;
      ok_cnt       <= ok_cnt_next;
      fail_cnt     <= fail_cnt_next;
      tmo_cnt      <= tmo_cnt_next;
      hum_ok_cnt   <= hum_ok_cnt_next;
      hum_fail_cnt <= hum_fail_cnt_next;
    end
  end

endmodule

### design/tsrs_out_stage.sv
// result register of the two-sensor read sequencer
// depends on tsrs_pkg
module tsrs_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tsrs_pkg::result_t result_next,
  input  logic              out_stall,
  output logic              out_valid,
  output tsrs_pkg::result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

### design/two_sensor_read_sequencer.sv
// top level of the two-sensor read sequencer
// depends on tsrs_pkg, tsrs_cfg, tsrs_in_stage, tsrs_core, tsrs_out_stage
// and the assertion macros in two_sensor_read_sequencer_macros.svh
//
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  kind, now_ms, flags, raw values
// result    out        out_valid/out_stall  status, command, held values, counters
// config    in         cfg_write            cfg_index, cfg_data
//
// one word per cycle unless out_stall holds the result register; a word waits
// in the input register until it steps, and the step loads the result register
// the step logic between the two registers is a few compares and 32-bit increments
// rst is synchronous: config returns to its defaults, the sequencer to idle
// in_stall rises only when both registers hold words and out_stall is high
`include "two_sensor_read_sequencer_macros.svh"

module two_sensor_read_sequencer (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] now_ms,
  input  logic        bus_match,
  input  logic        launch_ok,
  input  logic        response_ok,
  input  logic [15:0] humidity_raw_in,
  input  logic [15:0] temperature_raw_in,
  input  logic [15:0] gas_raw_in,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  command,
  output logic [15:0] comp_humidity,
  output logic [15:0] comp_temperature,
  output logic [15:0] gas_raw,
  output logic        sample_valid,
  output logic [31:0] good_cycles,
  output logic [31:0] failed_cycles,
  output logic [31:0] timeouts,
  output logic [31:0] humidity_reads_ok,
  output logic [31:0] humidity_read_errors
);

  tsrs_pkg::cfg_t    cfg;
  tsrs_pkg::item_t   in_item;
  tsrs_pkg::item_t   item;
  tsrs_pkg::result_t result_next;
  tsrs_pkg::result_t result;
  logic              full;
  logic              fire;

  // gather the input word
  assign in_item.kind               = kind;
  assign in_item.now_ms             = now_ms;
  assign in_item.bus_match          = bus_match;
  assign in_item.launch_ok          = launch_ok;
  assign in_item.response_ok        = response_ok;
  assign in_item.humidity_raw_in    = humidity_raw_in;
  assign in_item.temperature_raw_in = temperature_raw_in;
  assign in_item.gas_raw_in         = gas_raw_in;

  // the held word steps when the result register is free or being drained
  assign fire = full && (!out_valid || !out_stall);

  tsrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsrs_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fire     (fire),
    .full     (full),
    .item     (item)
  );

  tsrs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item),
    .cfg         (cfg),
    .result_next (result_next)
  );

  tsrs_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .result_next (result_next),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .result      (result)
  );

  // scatter the result word
  assign status               = result.status;
  assign command              = result.command;
  assign comp_humidity        = result.comp_humidity;
  assign comp_temperature     = result.comp_temperature;
  assign gas_raw              = result.gas_raw;
  assign sample_valid         = result.sample_valid;
  assign good_cycles          = result.good_cycles;
  assign failed_cycles        = result.failed_cycles;
  assign timeouts             = result.timeouts;
  assign humidity_reads_ok    = result.humidity_reads_ok;
  assign humidity_read_errors = result.humidity_read_errors;

  // a finished cycle always reports a sample and no bus command
  `TSRS_ASSERT_NOW(a_ready_has_sample, clk, rst,
    out_valid && status == tsrs_pkg::ST_READY,
    sample_valid && command == tsrs_pkg::CMD_NONE)

  // stall upstream only while a word is held
  `TSRS_ASSERT_NOW(a_stall_needs_word, clk, rst, in_stall, full)

  // the result register changes only when a word steps
  `TSRS_ASSERT_NEXT(a_result_holds, clk, rst, !fire && out_valid, $stable(result))

  // a held word with room downstream produces a result next cycle
  `TSRS_ASSERT_NEXT(a_fire_gives_result, clk, rst, fire, out_valid)

endmodule
